@@ src/tlife_pkg.sv @@
// Shared types and constants for the toroidal Life engine.
// Depends on nothing; the top level imports it.
`default_nettype none

package tlife_pkg;

   localparam int ROW_BITS  = 64;
   localparam int ROW_IDX_W = 5;
   localparam int MODE_W    = 2;

   localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ src/tlife_row_cell.sv @@
// One cell of the row ring: holds one grid row and takes its neighbor's row on a shift.
// Depends on nothing.
`default_nettype none

module tlife_row_cell #(
   parameter int WIDTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             shift_en,
   input  wire logic [WIDTH-1:0] shift_din,
   output logic      [WIDTH-1:0] row_dout
);

   logic [WIDTH-1:0] row_ff;
   logic [WIDTH-1:0] row_in;

   always_comb begin
      row_in = shift_en ? shift_din : row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

   assign row_dout = row_ff;

endmodule

`default_nettype wire

@@ src/tlife_rule.sv @@
// Next-generation rule for one row, given the rows above and below, with wrapped columns.
// Depends on nothing.
`default_nettype none

module tlife_rule #(
   parameter int WIDTH = 64
) (
   input  wire logic [WIDTH-1:0] up_row,
   input  wire logic [WIDTH-1:0] mid_row,
   input  wire logic [WIDTH-1:0] dn_row,
   output logic      [WIDTH-1:0] next_row
);

   for (genvar c = 0; c < WIDTH; c++) begin : g_col
      localparam int LF = (c + WIDTH - 1) % WIDTH;
      localparam int RT = (c + 1) % WIDTH;
      logic [3:0] count;

      always_comb begin
         count = 4'(up_row[LF]) + 4'(up_row[c]) + 4'(up_row[RT])
               + 4'(mid_row[LF]) + 4'(mid_row[RT])
               + 4'(dn_row[LF]) + 4'(dn_row[c]) + 4'(dn_row[RT]);
         next_row[c] = (count == 4'd3) || (mid_row[c] && (count == 4'd2));
      end
   end

endmodule

`default_nettype wire

@@ src/toroidal_life_engine_core.sv @@
// Top level of the toroidal Life engine: a ring of row cells and one rule unit.
// Depends on tlife_pkg, tlife_row_cell and tlife_rule.
//
// Usage: the req channel carries one word per command (mode, row_index, row_cells),
// the rsp channel carries result words (out_row_index, out_row_cells, last_row).
// The grid lives in a ring of GRID_HEIGHT row cells that rotates by one row per
// cycle during a sweep, unless a stalled advance holds it; a read takes the head row,
// and a write puts its new row into the tail cell in place of the head row.
// Every write, read and advance makes one full turn of the ring and then returns to
// idle; a read first passes a finish state to deliver its word.
// An advance computes row k during turn step k from the head row, the next row and
// a saved copy of the previous row, and delivers it as result word k; the last
// word carries last_row. A write gives no result; a meaningless mode is taken and
// ignored. A new command is taken only when the previous one is done.
// If the receiver stalls, the finished word waits in the output register and the
// ring holds still until it is taken. Reset clears the grid, state, step and rsp_valid.
`default_nettype none

module toroidal_life_engine_core #(
   parameter int GRID_WIDTH  = 64,
   parameter int GRID_HEIGHT = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [tlife_pkg::MODE_W-1:0]       req_mode,
   input  wire logic [tlife_pkg::ROW_IDX_W-1:0]    req_row_index,
   input  wire logic [tlife_pkg::ROW_BITS-1:0]     req_row_cells,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [tlife_pkg::ROW_IDX_W-1:0]    rsp_out_row_index,
   output logic      [tlife_pkg::ROW_BITS-1:0]     rsp_out_row_cells,
   output logic                                    rsp_last_row
);

   import tlife_pkg::*;

   localparam int IDX_W = $clog2(GRID_HEIGHT);

   logic [GRID_WIDTH-1:0] ring [GRID_HEIGHT];
   logic [GRID_WIDTH-1:0] tail_din;
   logic [GRID_WIDTH-1:0] up_row;
   logic [GRID_WIDTH-1:0] dn_row;
   logic [GRID_WIDTH-1:0] new_row;
   logic                  shift_en;
   logic                  last_step;
   logic                  row_match;
   logic                  rsp_free;

   state_type             state_ff, state_in;
   logic [IDX_W-1:0]      step_ff, step_in;
   logic [MODE_W-1:0]     op_mode_ff, op_mode_in;
   logic [ROW_IDX_W-1:0]  op_row_ff, op_row_in;
   logic [GRID_WIDTH-1:0] op_cells_ff, op_cells_in;
   logic [GRID_WIDTH-1:0] prev_ff, prev_in;
   logic [GRID_WIDTH-1:0] first_ff, first_in;
   logic [GRID_WIDTH-1:0] read_row_ff, read_row_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROW_IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [ROW_BITS-1:0]   rsp_cells_ff, rsp_cells_in;
   logic                  rsp_last_ff, rsp_last_in;

   for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_cell
      logic [GRID_WIDTH-1:0] din;
      if (i == GRID_HEIGHT - 1) begin : g_tail
         assign din = tail_din;
      end else begin : g_body
         assign din = ring[i+1];
      end
      tlife_row_cell #(
         .WIDTH(GRID_WIDTH)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .shift_din(din),
         .row_dout (ring[i])
      );
   end

   tlife_rule #(
      .WIDTH(GRID_WIDTH)
   ) u_rule (
      .up_row  (up_row),
      .mid_row (ring[0]),
      .dn_row  (dn_row),
      .next_row(new_row)
   );

   assign last_step = (step_ff == IDX_W'(GRID_HEIGHT - 1));
   assign row_match = (32'(step_ff) == 32'(op_row_ff));
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign up_row    = (step_ff == '0) ? ring[GRID_HEIGHT-1] : prev_ff;
   assign dn_row    = last_step ? first_ff : ring[1];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      op_mode_in   = op_mode_ff;
      op_row_in    = op_row_ff;
      op_cells_in  = op_cells_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      read_row_in  = read_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_cells_in = rsp_cells_ff;
      rsp_last_in  = rsp_last_ff;
      shift_en     = 1'b0;
      tail_din     = ring[0];
      req_ready    = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_mode_in  = req_mode;
               op_row_in   = req_row_index;
               op_cells_in = req_row_cells[GRID_WIDTH-1:0];
               read_row_in = '0;
               step_in     = '0;
               if (req_mode == MODE_WRITE || req_mode == MODE_ADVANCE ||
                   req_mode == MODE_READ) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_SWEEP: begin
            if (op_mode_ff == MODE_ADVANCE) begin
               tail_din = new_row;
               if (rsp_free) begin
                  shift_en     = 1'b1;
                  prev_in      = ring[0];
                  rsp_valid_in = 1'b1;
                  rsp_index_in = ROW_IDX_W'(step_ff);
                  rsp_cells_in = ROW_BITS'(new_row);
                  rsp_last_in  = last_step;
                  if (step_ff == '0) begin
                     first_in = ring[0];
                  end
               end
            end else begin
               shift_en = 1'b1;
               if (row_match) begin
                  if (op_mode_ff == MODE_WRITE) begin
                     tail_din = op_cells_ff;
                  end else begin
                     read_row_in = ring[0];
                  end
               end
            end
            if (shift_en) begin
               step_in = step_ff + IDX_W'(1);
               if (last_step) begin
                  step_in  = '0;
                  state_in = (op_mode_ff == MODE_READ) ? ST_FINISH : ST_IDLE;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = op_row_ff;
               rsp_cells_in = ROW_BITS'(read_row_ff);
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_mode_ff   <= op_mode_in;
      op_row_ff    <= op_row_in;
      op_cells_ff  <= op_cells_in;
      prev_ff      <= prev_in;
      first_ff     <= first_in;
      read_row_ff  <= read_row_in;
      rsp_index_ff <= rsp_index_in;
      rsp_cells_ff <= rsp_cells_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row_index = rsp_index_ff;
   assign rsp_out_row_cells = rsp_cells_ff;
   assign rsp_last_row      = rsp_last_ff;

endmodule

`default_nettype wire
